/* rtl/cfec_pkg.sv */
// Shared types and constants of the capture frequency and edge counter.
package cfec_pkg;

    localparam int DATA_W     = 32;
    localparam int CH_W       = 2;
    localparam int MASK_W     = 4;
    localparam int RATE_W     = 28;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RATE_W;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000000);

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MODE_MASK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAPTURE_RATE = 2'd2;

    // Transaction function codes.
    localparam logic FUNC_CAPTURE = 1'b0;
    localparam logic FUNC_REPORT  = 1'b1;

    typedef struct packed {
        logic              start;
        logic [RATE_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [RATE_W-1:0] quotient;
    } t_div_rsp;

endpackage

/* rtl/cfec_evt_if.sv */
// Event channel: edge captures and report requests.
interface cfec_evt_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [cfec_pkg::CH_W-1:0]   channel;
    logic [cfec_pkg::DATA_W-1:0] capture_time;

    modport source (output valid, output func, output channel, output capture_time,
                    input ready);
    modport sink   (input valid, input func, input channel, input capture_time,
                    output ready);
endinterface

/* rtl/cfec_rpt_if.sv */
// Report channel: one measured value per report request.
interface cfec_rpt_if;
    logic                       valid;
    logic                       ready;
    logic [cfec_pkg::CH_W-1:0]   report_channel;
    logic [cfec_pkg::DATA_W-1:0] value;
    logic                       is_frequency;
    logic                       zero_period;

    modport source (output valid, output report_channel, output value,
                    output is_frequency, output zero_period, input ready);
    modport sink   (input valid, input report_channel, input value,
                    input is_frequency, input zero_period, output ready);
endinterface

/* rtl/cfec_div.sv */
// Iterative restoring divider, one quotient bit per cycle.
module cfec_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cfec_pkg::t_div_req  i_req,
    output cfec_pkg::t_div_rsp  o_rsp
);

    localparam int QW    = cfec_pkg::RATE_W;
    localparam int DW    = cfec_pkg::DATA_W;
    localparam int CNT_W = $clog2(QW);

    logic            r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DW-1:0]   r_rem;
    logic [QW-1:0]   r_quo;
    logic [DW-1:0]   r_dvs;
    logic            r_done;

    logic [DW:0]     w_sh;
    logic [DW:0]     w_diff;
    logic            w_ge;

    always_comb begin
        w_sh   = {r_rem, r_quo[QW-1]};
        w_ge   = w_sh >= {1'b0, r_dvs};
        w_diff = w_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_rem <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
                r_quo <= {r_quo[QW-2:0], w_ge};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QW - 1);
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_last_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_cnt == '0 |=> r_done && !r_busy)
        else $error("divider did not finish after its last step");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("divider done held for more than one cycle");

endmodule

/* rtl/capture_frequency_and_edge_counter_top.sv */
// Top level of the four-channel reciprocal frequency and edge counter.
//
// The block takes edge-capture and report-request transactions on its event
// channel. A channel in count mode adds one to a wrapping 32-bit count per
// enabled capture. A channel in frequency mode stores its first armed capture,
// and on the second one divides the capture rate by the modular 32-bit period;
// the channel then stays disarmed until it is reported. Equal timestamps give
// a frequency of 0 with the zero-period flag set. A report returns the
// frequency or count of its channel and re-arms frequency mode. A second
// capture with a nonzero period starts the shared restoring divider, which
// produces one of its 28 quotient bits per cycle, and the event channel is
// held not ready until the quotient is written back. A report is taken only
// when the report output register is empty or is being emptied in the same
// cycle. Configuration writes are taken at any time but are intended for
// moments when no transaction is in flight.

module capture_frequency_and_edge_counter_top #(
    parameter int NUM_CHANNELS = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cfec_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [cfec_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    cfec_evt_if.sink                            i_evt,
    cfec_rpt_if.source                          o_rpt
);

    localparam int DW = cfec_pkg::DATA_W;

    typedef enum logic {S_IDLE, S_DIV} t_state;

    t_state r_state;

    // Configuration registers.
    logic [cfec_pkg::MASK_W-1:0] r_mode_mask;
    logic [cfec_pkg::MASK_W-1:0] r_en_mask;
    logic [cfec_pkg::RATE_W-1:0] r_rate;

    // Per-channel measurement state.
    logic [DW-1:0] r_first [NUM_CHANNELS];
    logic [DW-1:0] r_count [NUM_CHANNELS];
    logic [DW-1:0] r_freq  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_wait;
    logic [NUM_CHANNELS-1:0] r_armed;
    logic [NUM_CHANNELS-1:0] r_err;

    // Channel whose division is in progress, one-hot.
    logic [NUM_CHANNELS-1:0] r_div_sel;

    // Report output register.
    logic                        r_out_valid;
    logic [cfec_pkg::CH_W-1:0]   r_out_ch;
    logic [DW-1:0]               r_out_value;
    logic                        r_out_is_freq;
    logic                        r_out_zero;

    logic [NUM_CHANNELS-1:0] w_sel;
    logic                    w_ch_ok;
    logic [DW-1:0]           w_first;
    logic [DW-1:0]           w_count;
    logic [DW-1:0]           w_freq;
    logic                    w_wait;
    logic                    w_armed;
    logic                    w_err;
    logic                    w_mode;
    logic                    w_en;
    logic [DW-1:0]           w_period;
    logic                    w_accept;
    logic                    w_is_report;

    cfec_pkg::t_div_req w_div_req;
    cfec_pkg::t_div_rsp w_div_rsp;

    // Decode the addressed channel and select its state.
    always_comb begin
        w_first = '0;
        w_count = '0;
        w_freq  = '0;
        w_wait  = 1'b0;
        w_armed = 1'b0;
        w_err   = 1'b0;
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            w_sel[k] = int'(i_evt.channel) == k;
            if (w_sel[k]) begin
                w_first = r_first[k];
                w_count = r_count[k];
                w_freq  = r_freq[k];
                w_wait  = r_wait[k];
                w_armed = r_armed[k];
                w_err   = r_err[k];
            end
        end
    end

    assign w_ch_ok     = int'(i_evt.channel) < NUM_CHANNELS;
    assign w_mode      = r_mode_mask[i_evt.channel];
    assign w_en        = r_en_mask[i_evt.channel];
    assign w_period    = i_evt.capture_time - w_first;
    assign w_is_report = i_evt.func == cfec_pkg::FUNC_REPORT;

    assign i_evt.ready = (r_state == S_IDLE) && (!r_out_valid || o_rpt.ready);
    assign w_accept    = i_evt.valid && i_evt.ready;

    // The second armed capture of an enabled frequency-mode channel with a nonzero period.
    assign w_div_req.start    = w_accept && w_ch_ok && !w_is_report && w_en && w_mode
                                && w_armed && w_wait && (w_period != '0);
    assign w_div_req.dividend = r_rate;
    assign w_div_req.divisor  = w_period;

    cfec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode_mask <= '0;
            r_en_mask   <= '0;
            r_rate      <= cfec_pkg::RATE_RESET;
            r_wait      <= '0;
            r_armed     <= '1;
            r_err       <= '0;
            r_div_sel   <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_first[k] <= '0;
                r_count[k] <= '0;
                r_freq[k]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cfec_pkg::REG_MODE_MASK: begin
                        r_mode_mask <= i_cfg_data[cfec_pkg::MASK_W-1:0];
                    end
                    cfec_pkg::REG_ENABLE_MASK: begin
                        r_en_mask <= i_cfg_data[cfec_pkg::MASK_W-1:0];
                    end
                    cfec_pkg::REG_CAPTURE_RATE: begin
                        r_rate <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end

            if (o_rpt.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_ch_ok) begin
                        if (w_is_report) begin
                            r_out_valid   <= 1'b1;
                            r_out_ch      <= i_evt.channel;
                            r_out_value   <= w_mode ? w_freq : w_count;
                            r_out_is_freq <= w_mode;
                            r_out_zero    <= w_mode && w_err;
                            for (int k = 0; k < NUM_CHANNELS; k++) begin
                                if (w_sel[k] && w_mode) begin
                                    r_armed[k] <= 1'b1;
                                end
                            end
                        end else if (w_en) begin
                            for (int k = 0; k < NUM_CHANNELS; k++) begin
                                if (w_sel[k]) begin
                                    if (!w_mode) begin
                                        r_count[k] <= r_count[k] + 1'b1;
                                    end else if (r_armed[k]) begin
                                        if (!r_wait[k]) begin
                                            r_first[k] <= i_evt.capture_time;
                                            r_wait[k]  <= 1'b1;
                                        end else if (w_period == '0) begin
                                            r_freq[k]  <= '0;
                                            r_err[k]   <= 1'b1;
                                            r_wait[k]  <= 1'b0;
                                            r_armed[k] <= 1'b0;
                                        end
                                    end
                                end
                            end
                            if (w_div_req.start) begin
                                r_state   <= S_DIV;
                                r_div_sel <= w_sel;
                            end
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        for (int k = 0; k < NUM_CHANNELS; k++) begin
                            if (r_div_sel[k]) begin
                                r_freq[k]  <= DW'(w_div_rsp.quotient);
                                r_err[k]   <= 1'b0;
                                r_wait[k]  <= 1'b0;
                                r_armed[k] <= 1'b0;
                            end
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rpt.valid          = r_out_valid;
    assign o_rpt.report_channel = r_out_ch;
    assign o_rpt.value          = r_out_value;
    assign o_rpt.is_frequency   = r_out_is_freq;
    assign o_rpt.zero_period    = r_out_zero;

    a_div_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |=> r_state == S_DIV)
        else $error("division started without the sequencer waiting for it");

    a_div_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> $onehot(r_div_sel))
        else $error("division target is not a single channel");

    a_report_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_ch_ok && w_is_report |=> r_out_valid)
        else $error("accepted report transaction gave no output");

    a_done_only_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> r_state == S_DIV)
        else $error("quotient arrived outside a division");

endmodule

/* tb/tb_checker.sv */
// Checker of the frequency and edge counter: predicts each report and compares it.
module tb_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [cfec_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cfec_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cfec_evt_if                             i_evt,
    cfec_rpt_if                             i_rpt,
    output int                              o_err_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_CH = 4;

    typedef struct packed {
        logic [cfec_pkg::CH_W-1:0]   report_channel;
        logic [cfec_pkg::DATA_W-1:0] value;
        logic                        is_frequency;
        logic                        zero_period;
    } t_report;

    t_report awaited_reports[$];

    // Shadow of the registers and of the per-channel measurement state.
    logic [cfec_pkg::MASK_W-1:0] mode_mask;
    logic [cfec_pkg::MASK_W-1:0] enable_mask;
    logic [cfec_pkg::RATE_W-1:0] rate;
    logic [cfec_pkg::DATA_W-1:0] first_edge[N_CH];
    logic                        waiting_second[N_CH];
    logic                        armed[N_CH];
    logic [cfec_pkg::DATA_W-1:0] edges_seen[N_CH];
    logic [cfec_pkg::DATA_W-1:0] freq_hz[N_CH];
    logic                        zero_flag[N_CH];
    int                          errors;

    task automatic measure_event(input logic func, input logic [cfec_pkg::CH_W-1:0] ch,
                                 input logic [cfec_pkg::DATA_W-1:0] t);
        logic [cfec_pkg::DATA_W-1:0] period;
        t_report                     rep;
        if (func == cfec_pkg::FUNC_CAPTURE) begin
            if (enable_mask[ch]) begin
                if (!mode_mask[ch]) begin
                    edges_seen[ch] = edges_seen[ch] + 1;
                end else if (armed[ch]) begin
                    if (!waiting_second[ch]) begin
                        first_edge[ch]     = t;
                        waiting_second[ch] = 1'b1;
                    end else begin
                        period = t - first_edge[ch];
                        if (period == '0) begin
                            freq_hz[ch]   = '0;
                            zero_flag[ch] = 1'b1;
                        end else begin
                            freq_hz[ch]   = {{(cfec_pkg::DATA_W-cfec_pkg::RATE_W){1'b0}},
                                             rate} / period;
                            zero_flag[ch] = 1'b0;
                        end
                        waiting_second[ch] = 1'b0;
                        armed[ch]          = 1'b0;
                    end
                end
            end
        end else begin
            rep.report_channel = ch;
            if (mode_mask[ch]) begin
                rep.value        = freq_hz[ch];
                rep.is_frequency = 1'b1;
                rep.zero_period  = zero_flag[ch];
                armed[ch]        = 1'b1;
            end else begin
                rep.value        = edges_seen[ch];
                rep.is_frequency = 1'b0;
                rep.zero_period  = 1'b0;
            end
            awaited_reports.push_back(rep);
        end
    endtask

    always @(posedge i_clk) begin
        t_report want;
        if (!i_rst_n) begin
            mode_mask   = '0;
            enable_mask = '0;
            rate        = cfec_pkg::RATE_RESET;
            for (int c = 0; c < N_CH; c++) begin
                first_edge[c]     = '0;
                waiting_second[c] = 1'b0;
                armed[c]          = 1'b1;
                edges_seen[c]     = '0;
                freq_hz[c]        = '0;
                zero_flag[c]      = 1'b0;
            end
            awaited_reports.delete();
            errors = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cfec_pkg::REG_MODE_MASK:
                        mode_mask   = i_cfg_data[cfec_pkg::MASK_W-1:0];
                    cfec_pkg::REG_ENABLE_MASK:
                        enable_mask = i_cfg_data[cfec_pkg::MASK_W-1:0];
                    cfec_pkg::REG_CAPTURE_RATE:
                        rate        = i_cfg_data[cfec_pkg::RATE_W-1:0];
                    default: ;
                endcase
            end
            if (i_evt.valid && i_evt.ready) begin
                measure_event(i_evt.func, i_evt.channel, i_evt.capture_time);
            end
            if (i_rpt.valid && i_rpt.ready) begin
                if (awaited_reports.size() == 0) begin
                    $error("unrequested report: channel %0d value %0d",
                           i_rpt.report_channel, i_rpt.value);
                    errors++;
                end else begin
                    want = awaited_reports.pop_front();
                    if (i_rpt.report_channel !== want.report_channel) begin
                        $error("report_channel: expected %0d, actual %0d",
                               want.report_channel, i_rpt.report_channel);
                        errors++;
                    end
                    if (i_rpt.value !== want.value) begin
                        $error("value: expected %0d, actual %0d", want.value, i_rpt.value);
                        errors++;
                    end
                    if (i_rpt.is_frequency !== want.is_frequency) begin
                        $error("is_frequency: expected %0d, actual %0d",
                               want.is_frequency, i_rpt.is_frequency);
                        errors++;
                    end
                    if (i_rpt.zero_period !== want.zero_period) begin
                        $error("zero_period: expected %0d, actual %0d",
                               want.zero_period, i_rpt.zero_period);
                        errors++;
                    end
                end
            end
        end
        o_err_count <= errors;
        o_pending   <= awaited_reports.size();
    end

endmodule

/* tb/tb_top.sv */
// Top of the frequency and edge counter testbench: stimulus, idling and the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam realtime CLK_PERIOD     = 12.0;
    localparam int      TIMEOUT_CYCLES = 600_000;
    // The longest internal job is a division, so this many cycles after the last
    // report are ample for the block to go quiet.
    localparam int      DRAIN_CYCLES   = 40;
    localparam int      RANDOM_ITEMS   = 1950;
    localparam int      PHASE_ITEMS    = 60;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [cfec_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [cfec_pkg::CFG_DATA_W-1:0] i_cfg_data;

    cfec_evt_if evt ();
    cfec_rpt_if rpt ();

    int err_count;
    int reports_due;

    // When set, neither side inserts idle cycles, giving back-to-back stretches.
    bit no_idle;

    // What the stimulus knows of the current settings, used to shape items.
    logic [cfec_pkg::MASK_W-1:0] mode_now;
    logic [cfec_pkg::RATE_W-1:0] rate_now;
    int                          items_sent;

    capture_frequency_and_edge_counter_top #(
        .NUM_CHANNELS (4)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_evt      (evt),
        .o_rpt      (rpt)
    );

    tb_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_evt       (evt),
        .i_rpt       (rpt),
        .o_err_count (err_count),
        .o_pending   (reports_due)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2.0) i_clk = ~i_clk;
    end

    // A hung handshake must not stall the run for ever.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tb_top: done, errors");
        $finish;
    end

    // Report side: before each transaction the receiver holds ready low for a
    // random number of cycles, then keeps it high until the transaction goes
    // through. Valid is looked at on the falling edge, where it is settled,
    // so a high value there means the transaction completes at the next
    // rising edge.
    initial begin
        int stall;
        bit hit;
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 7);
            if (stall != 0) begin
                rpt.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rpt.ready <= 1'b1;
            do begin
                @(negedge i_clk);
                hit = rpt.valid;
                @(posedge i_clk);
            end while (!hit);
        end
    end

    // Every call starts and ends just after a rising edge. Write enable is high
    // for a single cycle and an idle edge follows, so back-to-back calls never
    // assign the same signal twice in one time step.
    task automatic write_reg(input logic [cfec_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cfec_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == cfec_pkg::REG_MODE_MASK) mode_now = data[cfec_pkg::MASK_W-1:0];
        if (idx == cfec_pkg::REG_CAPTURE_RATE) rate_now = data[cfec_pkg::RATE_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sends one event transaction. The sender first waits a random gap with
    // valid low, then presents the item and holds it until ready is seen on a
    // falling edge, meaning the transaction completes at the following rising
    // edge. Valid is left high so that a zero gap gives back-to-back items.
    task automatic send_event(input logic func, input logic [cfec_pkg::CH_W-1:0] ch,
                              input logic [cfec_pkg::DATA_W-1:0] t);
        int gap;
        bit took;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            evt.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        evt.valid        <= 1'b1;
        evt.func         <= func;
        evt.channel      <= ch;
        evt.capture_time <= t;
        do begin
            @(negedge i_clk);
            took = evt.ready;
            @(posedge i_clk);
        end while (!took);
        items_sent++;
    endtask

    // Stops the sender until every report in flight has been received, then
    // lets the block finish any division started by a capture, which has no
    // report of its own to wait for.
    task automatic settle();
        evt.valid <= 1'b0;
        do @(negedge i_clk); while (reports_due != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Periods lean towards the interesting spots: zero, tiny values where the
    // quotient is close to the rate, the full 32-bit range, the period that
    // wraps to all ones, and periods around the rate where the quotient is 0 or 1.
    function automatic logic [cfec_pkg::DATA_W-1:0] draw_period();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return cfec_pkg::DATA_W'($urandom_range(1, 16));
            2:       return cfec_pkg::DATA_W'($urandom_range(1, 100000));
            3:       return '1;
            4:       return cfec_pkg::DATA_W'(rate_now)
                            + cfec_pkg::DATA_W'($urandom_range(0, 2)) - 1;
            default: return cfec_pkg::DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [cfec_pkg::RATE_W-1:0] draw_rate();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return cfec_pkg::RATE_W'(1);
            2:       return '1;
            3:       return cfec_pkg::RATE_W'(200000000);
            4:       return cfec_pkg::RATE_RESET;
            default: return cfec_pkg::RATE_W'($urandom);
        endcase
    endfunction

    // One phase of random traffic. Most of it is complete measurements: a
    // pair of captures in frequency mode, or a short burst of edges in count
    // mode, each closed by a report. The rest are lone reports and noise that
    // hits disarmed channels, disabled channels and broken sequences.
    task automatic run_phase(input int n_items);
        int                          start_count;
        int                          kind;
        int                          burst;
        logic [cfec_pkg::CH_W-1:0]   ch;
        logic [cfec_pkg::DATA_W-1:0] t0;
        start_count = items_sent;
        while (items_sent - start_count < n_items) begin
            kind = $urandom_range(0, 9);
            ch   = cfec_pkg::CH_W'($urandom_range(0, 3));
            if (kind <= 5) begin
                if (mode_now[ch]) begin
                    t0 = cfec_pkg::DATA_W'($urandom);
                    send_event(cfec_pkg::FUNC_CAPTURE, ch, t0);
                    send_event(cfec_pkg::FUNC_CAPTURE, ch, t0 + draw_period());
                end else begin
                    burst = $urandom_range(1, 4);
                    repeat (burst) send_event(cfec_pkg::FUNC_CAPTURE, ch,
                                              cfec_pkg::DATA_W'($urandom));
                end
                send_event(cfec_pkg::FUNC_REPORT, ch, cfec_pkg::DATA_W'($urandom));
            end else if (kind <= 7) begin
                send_event(cfec_pkg::FUNC_REPORT, ch, cfec_pkg::DATA_W'($urandom));
            end else begin
                send_event(1'($urandom), ch, cfec_pkg::DATA_W'($urandom));
            end
        end
    endtask

    initial begin
        int en_pick;
        int mode_pick;
        logic [cfec_pkg::MASK_W-1:0] en_val;
        logic [cfec_pkg::MASK_W-1:0] mode_val;

        no_idle          = 1'b0;
        items_sent       = 0;
        mode_now         = '0;
        rate_now         = cfec_pkg::RATE_RESET;
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= cfec_pkg::REG_MODE_MASK;
        i_cfg_data       <= '0;
        evt.valid        <= 1'b0;
        evt.func         <= cfec_pkg::FUNC_CAPTURE;
        evt.channel      <= '0;
        evt.capture_time <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. With the reset settings every channel is disabled,
        // so the capture is dropped and the report shows an untouched count.
        send_event(cfec_pkg::FUNC_CAPTURE, 2'd0, 32'd123);
        send_event(cfec_pkg::FUNC_REPORT, 2'd0, 32'd0);
        settle();

        // Count mode on every channel: three captures on channel 1, then a report.
        write_reg(cfec_pkg::REG_ENABLE_MASK, cfec_pkg::CFG_DATA_W'(4'hF));
        send_event(cfec_pkg::FUNC_CAPTURE, 2'd1, 32'd3);
        send_event(cfec_pkg::FUNC_CAPTURE, 2'd1, 32'd4);
        send_event(cfec_pkg::FUNC_CAPTURE, 2'd1, 32'hFFFF_FFFF);
        send_event(cfec_pkg::FUNC_REPORT, 2'd1, 32'hFFFF_FFFF);
        settle();

        // Frequency mode at the highest nominal rate: a period that wraps the
        // timer, equal timestamps, the largest period and the smallest one.
        write_reg(cfec_pkg::REG_MODE_MASK, cfec_pkg::CFG_DATA_W'(4'hF));
        write_reg(cfec_pkg::REG_CAPTURE_RATE, cfec_pkg::CFG_DATA_W'(200000000));
        send_event(cfec_pkg::FUNC_CAPTURE, 2'd0, 32'hFFFF_FFF0);
        send_event(cfec_pkg::FUNC_CAPTURE, 2'd0, 32'h0000_0010);
        send_event(cfec_pkg::FUNC_CAPTURE, 2'd1, 32'd5);
        send_event(cfec_pkg::FUNC_CAPTURE, 2'd1, 32'd5);
        send_event(cfec_pkg::FUNC_CAPTURE, 2'd2, 32'd0);
        send_event(cfec_pkg::FUNC_CAPTURE, 2'd2, 32'hFFFF_FFFF);
        send_event(cfec_pkg::FUNC_CAPTURE, 2'd3, 32'd100);
        send_event(cfec_pkg::FUNC_CAPTURE, 2'd3, 32'd101);
        // Channel 3 is now disarmed, so this capture must leave it alone.
        send_event(cfec_pkg::FUNC_CAPTURE, 2'd3, 32'd200);
        send_event(cfec_pkg::FUNC_REPORT, 2'd0, 32'd0);
        send_event(cfec_pkg::FUNC_REPORT, 2'd1, 32'd0);
        send_event(cfec_pkg::FUNC_REPORT, 2'd2, 32'd0);
        send_event(cfec_pkg::FUNC_REPORT, 2'd3, 32'd0);
        send_event(cfec_pkg::FUNC_REPORT, 2'd1, 32'd0);
        // A report between the two captures keeps the pending first edge.
        send_event(cfec_pkg::FUNC_CAPTURE, 2'd0, 32'd7);
        send_event(cfec_pkg::FUNC_REPORT, 2'd0, 32'd0);
        settle();

        // A rate of zero gives a frequency of zero without the error flag.
        write_reg(cfec_pkg::REG_CAPTURE_RATE, cfec_pkg::CFG_DATA_W'(0));
        send_event(cfec_pkg::FUNC_CAPTURE, 2'd0, 32'd50);
        send_event(cfec_pkg::FUNC_REPORT, 2'd0, 32'd0);
        settle();

        // Back to count mode: stored counts survive the mode change.
        write_reg(cfec_pkg::REG_MODE_MASK, cfec_pkg::CFG_DATA_W'(4'h0));
        send_event(cfec_pkg::FUNC_REPORT, 2'd1, 32'd0);
        send_event(cfec_pkg::FUNC_REPORT, 2'd2, 32'd0);

        // Random phases. Each one starts from an idle block with a fresh
        // setting of all three registers, and some run without any idling.
        while (items_sent < RANDOM_ITEMS) begin
            settle();
            mode_pick = $urandom_range(0, 5);
            mode_val  = (mode_pick == 0) ? 4'h0 :
                        (mode_pick == 1) ? 4'hF : cfec_pkg::MASK_W'($urandom);
            en_pick   = $urandom_range(0, 9);
            en_val    = (en_pick == 0) ? 4'h0 :
                        (en_pick <= 6) ? 4'hF : cfec_pkg::MASK_W'($urandom);
            write_reg(cfec_pkg::REG_MODE_MASK, cfec_pkg::CFG_DATA_W'(mode_val));
            write_reg(cfec_pkg::REG_ENABLE_MASK, cfec_pkg::CFG_DATA_W'(en_val));
            write_reg(cfec_pkg::REG_CAPTURE_RATE, cfec_pkg::CFG_DATA_W'(draw_rate()));
            no_idle = ($urandom_range(0, 3) == 0);
            run_phase(PHASE_ITEMS);
        end

        no_idle = 1'b0;
        settle();
        if (err_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/cfec_pkg.sv
rtl/cfec_evt_if.sv
rtl/cfec_rpt_if.sv
rtl/cfec_div.sv
rtl/capture_frequency_and_edge_counter_top.sv
tb/tb_checker.sv
tb/tb_top.sv
